/* rtl/mbe_pkg.sv */
// Shared types, constants and helpers for the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package mbe_pkg;

    // Field and register widths
    localparam int PIX_W      = 24;
    localparam int COUNT_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int DIM_CFG_W  = 13;

    // Fixed-point format: signed Q4.28
    localparam int FRAC_BITS = 28;
    localparam int Q_W       = 32;
    localparam int PROD_W    = 2 * Q_W;

    // Divider numerator covers index shifted up by FRAC_BITS + 1
    localparam int NUM_W  = PIX_W + FRAC_BITS + 1;
    localparam int STEP_W = $clog2(NUM_W + 1);

    // Saturation input width for the z update
    localparam int SAT_W = PROD_W - FRAC_BITS + 2;

    // Defaults and reset values
    localparam int MAX_DIM_DEF     = 4096;
    localparam int DIM_RESET       = 1024;
    localparam int LIMIT_RESET     = 100;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_DIM  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(1);

    // Q4.28 constants
    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
    localparam logic signed [Q_W-1:0] Q_ONE = Q_W'(1) << FRAC_BITS;

    // Escape bound |z|^2 > 4 in Q8.56
    localparam logic [PROD_W-1:0] ESC_LIM = PROD_W'(4) << (2 * FRAC_BITS);

    // Largest quotient that maps to cy without saturating
    localparam logic [NUM_W-1:0] CY_SAT_THR =
        NUM_W'({1'b0, {(Q_W-1){1'b1}}}) + (NUM_W'(1) << FRAC_BITS);

    // Divider control
    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    // Clamp a wide signed value into the Q4.28 range
    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic fits;
        fits = (v[SAT_W-1:Q_W-1] == {(SAT_W-Q_W+1){1'b0}}) ||
               (v[SAT_W-1:Q_W-1] == {(SAT_W-Q_W+1){1'b1}});
        if (fits) begin
            return v[Q_W-1:0];
        end else if (v[SAT_W-1]) begin
            return Q_MIN;
        end else begin
            return Q_MAX;
        end
    endfunction

endpackage

/* rtl/mbe_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module mbe_div #(
    parameter int DEN_W = 26
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mbe_pkg::t_div_ctl           i_ctl,
    input  logic [mbe_pkg::NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_done,
    output logic [mbe_pkg::NUM_W-1:0]   o_quot,
    output logic [DEN_W-1:0]            o_rem
);

    logic [mbe_pkg::NUM_W-1:0]  r_num;
    logic [mbe_pkg::NUM_W-1:0]  r_quot;
    logic [DEN_W-1:0]           r_rem;
    logic [DEN_W-1:0]           r_den;
    logic [mbe_pkg::STEP_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    // Shift in the next numerator bit and try a subtract
    always_comb begin
        trial = {r_rem, r_num[mbe_pkg::NUM_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    // Load operands on start, then advance one bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quot <= '0;
                r_cnt  <= i_ctl.steps;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_num  <= {r_num[mbe_pkg::NUM_W-2:0], 1'b0};
                r_rem  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                r_quot <= {r_quot[mbe_pkg::NUM_W-2:0], ge};
                r_cnt  <= r_cnt - mbe_pkg::STEP_W'(1);
                if (r_cnt == mbe_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

/* rtl/mandelbrot_escape_time.sv */
// Per pixel at the default widths, the serial divider runs 24 + 43 + 53 steps (index mod dim,
// cx, cy); the shared 32x32 multiplier then serves each z step through S_IT_XX, S_IT_YY,
// S_IT_XY and S_IT_UPD, one z step per iteration_count plus one for the final escape check
// when the point escapes; the result is then loaded into the output register.
// Pixels are taken one at a time, and a new one is taken while o_valid waits on i_stall.
// Reset (synchronous, active low): idle, output empty, image_dim 1024, iteration_limit 100.
`timescale 1ns / 1ps

module mandelbrot_escape_time #(
    parameter int MAX_DIM = mbe_pkg::MAX_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pixel input
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [mbe_pkg::PIX_W-1:0]        i_pixel_index,
    // Result output
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [mbe_pkg::COUNT_W-1:0]      o_iteration_count,
    output logic                             o_hit_limit,
    // Register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mbe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int DEN_W   = 2 * DIM_W;
    localparam int R7_W    = DIM_W + 3;
    localparam int CX_STEP = R7_W + mbe_pkg::FRAC_BITS - 1;
    localparam int DIM_RST = (mbe_pkg::DIM_RESET > MAX_DIM) ? MAX_DIM : mbe_pkg::DIM_RESET;
    localparam int Q_W     = mbe_pkg::Q_W;
    localparam int PROD_W  = mbe_pkg::PROD_W;
    localparam int SAT_W   = mbe_pkg::SAT_W;
    localparam int FRAC    = mbe_pkg::FRAC_BITS;
    localparam int NUM_W   = mbe_pkg::NUM_W;
    localparam int CNT_W   = mbe_pkg::COUNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_R,
        S_DIV_CX,
        S_DIV_CY,
        S_IT_XX,
        S_IT_YY,
        S_IT_XY,
        S_IT_UPD
    } t_state;

    typedef enum logic {
        O_FREE,
        O_DONE
    } t_fin;

    t_state                    r_state;
    t_fin                      r_fin;
    logic [DIM_W-1:0]          r_dim;
    logic [CNT_W-1:0]          r_limit;
    logic [mbe_pkg::PIX_W-1:0] r_idx;
    logic [DEN_W-1:0]          r_dim2;
    logic signed [Q_W-1:0]     r_cx;
    logic signed [Q_W-1:0]     r_cy;
    logic signed [Q_W-1:0]     r_x;
    logic signed [Q_W-1:0]     r_y;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [PROD_W-1:0]  r_xx;
    logic [PROD_W-1:0]         r_sum;
    logic signed [PROD_W-FRAC-1:0] r_diff;
    logic [CNT_W-1:0]          r_count;
    logic                      r_out_valid;
    logic [CNT_W-1:0]          r_out_count;
    logic                      r_out_hit;

    logic                      in_xfer;
    logic                      out_free;
    logic [mbe_pkg::CFG_DATA_W:0] cfg_dim;
    logic [DIM_W-1:0]          dim_clamped;

    logic signed [Q_W-1:0]     mul_a;
    logic signed [Q_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]  mul_p;

    mbe_pkg::t_div_ctl         div_ctl;
    logic [NUM_W-1:0]          div_num;
    logic [DEN_W-1:0]          div_den;
    logic                      div_done;
    logic [NUM_W-1:0]          div_quot;
    logic [DEN_W-1:0]          div_rem;

    logic [R7_W-1:0]           r7;
    logic signed [SAT_W-1:0]   x_wide;
    logic signed [SAT_W-1:0]   y_wide;
    logic [CNT_W-1:0]          count_inc;

    assign in_xfer     = i_valid && (r_state == S_IDLE) && (r_fin == O_FREE);
    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = (r_state != S_IDLE) || (r_fin != O_FREE);
    assign o_cfg_ready = 1'b1;

    // Clamp the written dimension to 1..MAX_DIM
    always_comb begin
        cfg_dim = {1'b0, i_cfg_data};
        if (cfg_dim == '0) begin
            dim_clamped = DIM_W'(1);
        end else if (32'(cfg_dim) > 32'(MAX_DIM)) begin
            dim_clamped = DIM_W'(MAX_DIM);
        end else begin
            dim_clamped = DIM_W'(cfg_dim);
        end
    end

    // Shared multiplier operand select
    always_comb begin
        case (r_state)
            S_IT_XX: begin
                mul_a = r_x;
                mul_b = r_x;
            end
            S_IT_YY: begin
                mul_a = r_y;
                mul_b = r_y;
            end
            S_IT_XY: begin
                mul_a = r_x;
                mul_b = r_y;
            end
            default: begin
                mul_a = Q_W'(r_dim);
                mul_b = Q_W'(r_dim);
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Divider requests: index mod dim, then cx, then cy
    always_comb begin
        r7          = ({3'b000, div_rem[DIM_W-1:0]} << 3) - {3'b000, div_rem[DIM_W-1:0]};
        div_ctl     = '0;
        div_num     = {i_pixel_index, {(NUM_W - mbe_pkg::PIX_W){1'b0}}};
        div_den     = DEN_W'(r_dim);
        case (r_state)
            S_IDLE: begin
                div_ctl.start = in_xfer;
                div_ctl.steps = mbe_pkg::STEP_W'(mbe_pkg::PIX_W);
            end
            S_DIV_R: begin
                div_ctl.start = div_done;
                div_ctl.steps = mbe_pkg::STEP_W'(CX_STEP);
                div_num       = {r7, {(NUM_W - R7_W){1'b0}}};
            end
            S_DIV_CX: begin
                div_ctl.start = div_done;
                div_ctl.steps = mbe_pkg::STEP_W'(NUM_W);
                div_num       = {r_idx, {(FRAC + 1){1'b0}}};
                div_den       = r_dim2;
            end
            default: begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    mbe_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (div_ctl),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // z update terms: floor shifts are the upper product bits
    always_comb begin
        x_wide    = SAT_W'(r_diff) + SAT_W'(r_cx);
        y_wide    = SAT_W'($signed(r_prod[PROD_W-1:FRAC-1])) + SAT_W'(r_cy);
        count_inc = r_count + CNT_W'(1);
    end

    // Sequencer, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fin       <= O_FREE;
            r_out_valid <= 1'b0;
            r_dim       <= DIM_W'(DIM_RST);
            r_limit     <= CNT_W'(mbe_pkg::LIMIT_RESET);
        end else begin
            // Register writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    mbe_pkg::REG_IMAGE_DIM:  r_dim   <= dim_clamped;
                    mbe_pkg::REG_ITER_LIMIT: r_limit <= i_cfg_data[CNT_W-1:0];
                    default: ;
                endcase
            end

            // Hand a finished result to the output register, else drop it once taken
            if (r_fin == O_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_count <= r_count;
                r_out_hit   <= (r_count == r_limit);
                r_fin       <= O_FREE;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_idx   <= i_pixel_index;
                        r_dim2  <= mul_p[DEN_W-1:0];
                        r_state <= S_DIV_R;
                    end
                end
                S_DIV_R: begin
                    if (div_done) begin
                        r_state <= S_DIV_CX;
                    end
                end
                S_DIV_CX: begin
                    if (div_done) begin
                        r_cx    <= div_quot[Q_W-1:0] - mbe_pkg::Q_ONE;
                        r_state <= S_DIV_CY;
                    end
                end
                S_DIV_CY: begin
                    if (div_done) begin
                        if (div_quot > mbe_pkg::CY_SAT_THR) begin
                            r_cy <= mbe_pkg::Q_MAX;
                        end else begin
                            r_cy <= div_quot[Q_W-1:0] - mbe_pkg::Q_ONE;
                        end
                        r_x     <= '0;
                        r_y     <= '0;
                        r_count <= '0;
                        if (r_limit == '0) begin
                            r_fin   <= O_DONE;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_IT_XX;
                        end
                    end
                end
                S_IT_XX: begin
                    r_prod  <= mul_p;
                    r_state <= S_IT_YY;
                end
                S_IT_YY: begin
                    r_xx    <= r_prod;
                    r_prod  <= mul_p;
                    r_state <= S_IT_XY;
                end
                S_IT_XY: begin
                    r_sum   <= r_xx + r_prod;
                    r_diff  <= (PROD_W-FRAC)'((r_xx - r_prod) >>> FRAC);
                    r_prod  <= mul_p;
                    r_state <= S_IT_UPD;
                end
                S_IT_UPD: begin
                    if (r_sum > mbe_pkg::ESC_LIM) begin
                        r_fin   <= O_DONE;
                        r_state <= S_IDLE;
                    end else begin
                        r_x     <= mbe_pkg::sat_q(x_wide);
                        r_y     <= mbe_pkg::sat_q(y_wide);
                        r_count <= count_inc;
                        if (count_inc == r_limit) begin
                            r_fin   <= O_DONE;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_IT_XX;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_hit_limit       = r_out_hit;

endmodule
